@@ sv/event_queue_coalescing_core_macros.svh @@
// assertion macros for the event queue core
// used by modules that carry concurrent checks
`ifndef EVENT_QUEUE_COALESCING_CORE_MACROS_SVH
`define EVENT_QUEUE_COALESCING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EQC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EQC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EQC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EQC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/eqc_pkg.sv @@
// shared types and constants for the event queue core
// no dependencies
package eqc_pkg;
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = 36 + 64 + 32 + 64;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0, OP_POP = 3'd1, OP_PEEK = 3'd2, OP_DISCARD = 3'd3,
    OP_FLUSH = 3'd4, OP_DIAG = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    EV_KEYDOWN = 4'd0, EV_KEYUP = 4'd1, EV_MOVE = 4'd2, EV_BTNDOWN = 4'd3,
    EV_BTNUP = 4'd4, EV_SCROLL = 4'd5, EV_CLOSE = 4'd6, EV_RESIZE = 4'd7,
    EV_FOCUS = 4'd8, EV_BLUR = 4'd9, EV_PAINT = 4'd10, EV_TIMER = 4'd11
  } ev_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_MERGED = 2'd1, ST_REJECT = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] flags;
    logic [15:0] window;
    logic [3:0]  etype;
    logic [31:0] value_b;
    logic [31:0] value_a;
    logic [15:0] delta_y;
    logic [15:0] delta_x;
    logic [63:0] timestamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MERGE, S_SHOW, S_OUT
  } state_t;

  // memory port bundle between control and storage
  typedef struct packed {
    logic   we;
    ptr_t   waddr;
    entry_t wdata;
    ptr_t   raddr;
  } mem_req_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    if (p == '0) r = ptr_t'(QUEUE_DEPTH - 1);
    else r = p - ptr_t'(1);
    return r;
  endfunction

  function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
    logic signed [16:0] s;
    logic [15:0] r;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) r = s[16] ? 16'h8000 : 16'h7fff;
    else r = s[15:0];
    return r;
  endfunction
endpackage

@@ sv/eqc_store.sv @@
// event entry storage: one synchronous ram, one write and one read port
// depends on eqc_pkg
module eqc_store (
  input  logic                clk,
  input  eqc_pkg::mem_req_t   req,
  output eqc_pkg::entry_t     rdata
);
  eqc_pkg::entry_t mem [eqc_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

@@ sv/eqc_ctrl.sv @@
// sequencer: pointers, counters, scans and read-modify-write of the entry ram
// depends on eqc_pkg, eqc_store and the macro header
`include "event_queue_coalescing_core_macros.svh"
module eqc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [3:0]            in_event_type,
  input  logic [15:0]           in_window_id,
  input  logic signed [31:0]    in_value_a,
  input  logic signed [31:0]    in_value_b,
  input  logic signed [15:0]    in_delta_x,
  input  logic signed [15:0]    in_delta_y,
  input  logic [15:0]           in_flags,
  input  logic [63:0]           in_timestamp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [3:0]            out_type,
  output logic [15:0]           out_window,
  output logic signed [31:0]    out_value_a,
  output logic signed [31:0]    out_value_b,
  output logic signed [15:0]    out_delta_x,
  output logic signed [15:0]    out_delta_y,
  output logic [15:0]           out_flags,
  output logic [63:0]           out_timestamp,
  output logic [6:0]            out_pending,
  output logic [63:0]           out_dropped_total,
  output logic [6:0]            out_high_watermark
);
  eqc_pkg::state_t  state_r, state_nxt;
  eqc_pkg::ptr_t    wp_r, wp_nxt, rp_r, rp_nxt;
  eqc_pkg::cnt_t    fill_r, fill_nxt, peak_r, peak_nxt;
  logic [63:0]      drop_r, drop_nxt;
  eqc_pkg::op_t     op_r, op_nxt;
  eqc_pkg::entry_t  ent_r, ent_nxt;
  eqc_pkg::ptr_t    src_r, src_nxt, dst_r, dst_nxt;
  eqc_pkg::cnt_t    idx_r, idx_nxt, kept_r, kept_nxt;
  logic             hit_r, hit_nxt;
  eqc_pkg::status_t st_r, st_nxt;
  eqc_pkg::entry_t  res_r, res_nxt;
  logic             ov_r, ov_nxt;
  eqc_pkg::mem_req_t req;
  eqc_pkg::entry_t  rdata;

  eqc_store u_store (.clk(clk), .req(req), .rdata(rdata));

  eqc_pkg::entry_t shaped;
  logic is_mouse, is_merge_type, full;
  logic [3:0] rt;

  always_comb begin
    rt = in_event_type;
    shaped = '0;
    shaped.etype = rt;
    shaped.timestamp = in_timestamp;
    is_mouse = (rt >= 4'(eqc_pkg::EV_MOVE)) && (rt <= 4'(eqc_pkg::EV_SCROLL));
    is_merge_type = (rt == 4'(eqc_pkg::EV_MOVE)) || (rt == 4'(eqc_pkg::EV_SCROLL));
    if (is_mouse) begin
      shaped.value_a = in_value_a;
      shaped.value_b = in_value_b;
      shaped.flags = {8'h00, in_flags[7:0]};
      if (rt == 4'(eqc_pkg::EV_MOVE)) shaped.delta_x = in_delta_x;
      if (is_merge_type) shaped.delta_y = in_delta_y;
    end else if (rt <= 4'(eqc_pkg::EV_KEYUP)) begin
      shaped.value_a = in_value_a;
      shaped.flags = in_flags;
      shaped.window = in_window_id;
    end else begin
      shaped.window = in_window_id;
      if (rt == 4'(eqc_pkg::EV_RESIZE)) begin
        shaped.value_a = in_value_a;
        shaped.value_b = in_value_b;
      end
      if (rt == 4'(eqc_pkg::EV_TIMER)) shaped.value_a = in_value_a;
    end
  end

  assign full = (fill_r == eqc_pkg::cnt_t'(eqc_pkg::QUEUE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    wp_nxt = wp_r; rp_nxt = rp_r; fill_nxt = fill_r; peak_nxt = peak_r;
    drop_nxt = drop_r; op_nxt = op_r; ent_nxt = ent_r;
    src_nxt = src_r; dst_nxt = dst_r; idx_nxt = idx_r; kept_nxt = kept_r;
    hit_nxt = hit_r; st_nxt = st_r; res_nxt = res_r; ov_nxt = ov_r;
    req = '0;
    req.raddr = src_r;
    in_ready = 1'b0;
    unique case (state_r)
      eqc_pkg::S_IDLE: begin
        in_ready = !ov_r;
        if (in_valid && !ov_r) begin
          op_nxt = eqc_pkg::op_t'(in_opcode);
          ent_nxt = shaped;
          res_nxt = '0;
          st_nxt = eqc_pkg::ST_DONE;
          src_nxt = rp_r; dst_nxt = rp_r;
          idx_nxt = '0; kept_nxt = '0; hit_nxt = 1'b0;
          state_nxt = eqc_pkg::S_OUT;
          unique case (in_opcode)
            3'(eqc_pkg::OP_PUSH): begin
              if (rt > 4'(eqc_pkg::EV_TIMER)) begin
                st_nxt = eqc_pkg::ST_REJECT;
              end else if (is_merge_type && fill_r != '0) begin
                src_nxt = eqc_pkg::ptr_dec(wp_r);
                state_nxt = eqc_pkg::S_MERGE;
              end else if (rt == 4'(eqc_pkg::EV_PAINT) ||
                           rt == 4'(eqc_pkg::EV_TIMER)) begin
                if (in_window_id == '0) st_nxt = eqc_pkg::ST_REJECT;
                else state_nxt = eqc_pkg::S_SCAN_RD;
              end else begin
                state_nxt = eqc_pkg::S_SCAN_RD;
                idx_nxt = fill_r; // nothing to scan, store directly
              end
            end
            3'(eqc_pkg::OP_POP), 3'(eqc_pkg::OP_PEEK): begin
              if (fill_r == '0) st_nxt = eqc_pkg::ST_EMPTY;
              else state_nxt = eqc_pkg::S_SHOW;
            end
            3'(eqc_pkg::OP_DISCARD): begin
              // discard target is the raw window, whatever the type field says
              ent_nxt.window = in_window_id;
              if (in_window_id != '0 && fill_r != '0) state_nxt = eqc_pkg::S_SCAN_RD;
            end
            3'(eqc_pkg::OP_FLUSH): begin
              wp_nxt = '0; rp_nxt = '0; fill_nxt = '0;
            end
            3'(eqc_pkg::OP_DIAG): begin
              peak_nxt = fill_r; drop_nxt = '0;
            end
            default: st_nxt = eqc_pkg::ST_REJECT;
          endcase
          // read for merge or show lands in the next cycle
          req.raddr = src_nxt;
        end
      end
      // issue read of src, compare next cycle
      eqc_pkg::S_SCAN_RD: begin
        if (idx_r == fill_r) begin
          if (op_r == eqc_pkg::OP_DISCARD) begin
            res_nxt.value_a = 32'(fill_r - kept_r);
            fill_nxt = kept_r;
            wp_nxt = (kept_r == '0) ? '0 : dst_r;
            if (kept_r == '0) rp_nxt = '0;
          end else if (hit_r) begin
            st_nxt = eqc_pkg::ST_MERGED;
          end else begin
            req.we = 1'b1; req.waddr = wp_r; req.wdata = ent_r;
            wp_nxt = eqc_pkg::ptr_inc(wp_r);
            if (full) begin
              rp_nxt = eqc_pkg::ptr_inc(rp_r);
              if (drop_r != '1) drop_nxt = drop_r + 64'd1;
            end else begin
              fill_nxt = fill_r + eqc_pkg::cnt_t'(1);
              if (fill_r + eqc_pkg::cnt_t'(1) > peak_r) peak_nxt = fill_r + eqc_pkg::cnt_t'(1);
            end
          end
          state_nxt = eqc_pkg::S_OUT;
        end else begin
          state_nxt = eqc_pkg::S_SCAN_CHK;
        end
      end
      eqc_pkg::S_SCAN_CHK: begin
        idx_nxt = idx_r + eqc_pkg::cnt_t'(1);
        src_nxt = eqc_pkg::ptr_inc(src_r);
        req.raddr = eqc_pkg::ptr_inc(src_r);
        if (op_r == eqc_pkg::OP_DISCARD) begin
          // compact kept entries toward the head; dst never passes src
          if (rdata.window != ent_r.window) begin
            req.we = 1'b1; req.waddr = dst_r; req.wdata = rdata;
            dst_nxt = eqc_pkg::ptr_inc(dst_r);
            kept_nxt = kept_r + eqc_pkg::cnt_t'(1);
          end
        end else if (rdata.etype == ent_r.etype && rdata.window == ent_r.window &&
                     (ent_r.etype != 4'(eqc_pkg::EV_TIMER) ||
                      rdata.value_a == ent_r.value_a)) begin
          hit_nxt = 1'b1;
        end
        state_nxt = eqc_pkg::S_SCAN_RD;
      end
      eqc_pkg::S_MERGE: begin
        if (rdata.etype == ent_r.etype && rdata.window == '0) begin
          req.we = 1'b1; req.waddr = src_r;
          req.wdata = ent_r;
          req.wdata.delta_y = eqc_pkg::sat_add16(rdata.delta_y, ent_r.delta_y);
          req.wdata.delta_x = (ent_r.etype == 4'(eqc_pkg::EV_MOVE)) ?
                              eqc_pkg::sat_add16(rdata.delta_x, ent_r.delta_x) : '0;
          st_nxt = eqc_pkg::ST_MERGED;
          state_nxt = eqc_pkg::S_OUT;
        end else begin
          idx_nxt = fill_r;
          state_nxt = eqc_pkg::S_SCAN_RD;
        end
      end
      eqc_pkg::S_SHOW: begin
        res_nxt = rdata;
        if (op_r == eqc_pkg::OP_POP) begin
          rp_nxt = eqc_pkg::ptr_inc(rp_r);
          fill_nxt = fill_r - eqc_pkg::cnt_t'(1);
        end
        state_nxt = eqc_pkg::S_OUT;
      end
      eqc_pkg::S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = eqc_pkg::S_IDLE;
      end
      default: state_nxt = eqc_pkg::S_IDLE;
    endcase
    if (ov_r && out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eqc_pkg::S_IDLE;
      wp_r <= '0; rp_r <= '0; fill_r <= '0; peak_r <= '0; drop_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r <= wp_nxt; rp_r <= rp_nxt; fill_r <= fill_nxt; peak_r <= peak_nxt;
      drop_r <= drop_nxt; ov_r <= ov_nxt;
    end
    op_r <= op_nxt; ent_r <= ent_nxt; src_r <= src_nxt; dst_r <= dst_nxt;
    idx_r <= idx_nxt; kept_r <= kept_nxt; hit_r <= hit_nxt; st_r <= st_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_type = res_r.etype;
  assign out_window = res_r.window;
  assign out_value_a = res_r.value_a;
  assign out_value_b = res_r.value_b;
  assign out_delta_x = res_r.delta_x;
  assign out_delta_y = res_r.delta_y;
  assign out_flags = res_r.flags;
  assign out_timestamp = res_r.timestamp;
  assign out_pending = 7'(fill_r);
  assign out_dropped_total = drop_r;
  assign out_high_watermark = 7'(peak_r);

  `EQC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= eqc_pkg::cnt_t'(eqc_pkg::QUEUE_DEPTH))
  `EQC_ASSERT_IMP(a_peak_ge_fill, clk, rst_n, state_r == eqc_pkg::S_IDLE, peak_r >= fill_r)
  `EQC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, ov_r, !in_ready)
  `EQC_ASSERT_NXT(a_out_follows, clk, rst_n, state_r == eqc_pkg::S_OUT, ov_r)
endmodule

@@ sv/event_queue_coalescing_core.sv @@
// event queue core top level: one-word-at-a-time sequencer over an entry ram
// depends on eqc_pkg and eqc_ctrl
//
// channel | direction | handshake
// in_*    | input     | in_valid / in_ready
// out_*   | output    | out_valid / out_ready
//
// push of paint or timer and discard of a nonzero window scan the queue
// the scan runs through the single read port of the entry ram
// reset clears pointers, counts and the output valid; entries and result fields stay unknown
// a new word is taken only after the previous result is delivered
module event_queue_coalescing_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_opcode,
  input  logic [3:0]            in_event_type,
  input  logic [15:0]           in_window_id,
  input  logic signed [31:0]    in_value_a,
  input  logic signed [31:0]    in_value_b,
  input  logic signed [15:0]    in_delta_x,
  input  logic signed [15:0]    in_delta_y,
  input  logic [15:0]           in_flags,
  input  logic [63:0]           in_timestamp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [3:0]            out_type,
  output logic [15:0]           out_window,
  output logic signed [31:0]    out_value_a,
  output logic signed [31:0]    out_value_b,
  output logic signed [15:0]    out_delta_x,
  output logic signed [15:0]    out_delta_y,
  output logic [15:0]           out_flags,
  output logic [63:0]           out_timestamp,
  output logic [6:0]            out_pending,
  output logic [63:0]           out_dropped_total,
  output logic [6:0]            out_high_watermark
);
  eqc_ctrl u_ctrl (.*);
endmodule

@@ dv/eqc_checker.sv @@
// checker for the event queue core: watches both channels, predicts each result
// depends on eqc_pkg; instantiated by tb_top beside the block
`timescale 1ns / 1ps
module eqc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [3:0]  in_event_type,
  input  logic [15:0] in_window_id,
  input  logic [31:0] in_value_a,
  input  logic [31:0] in_value_b,
  input  logic [15:0] in_delta_x,
  input  logic [15:0] in_delta_y,
  input  logic [15:0] in_flags,
  input  logic [63:0] in_timestamp,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_type,
  input  logic [15:0] out_window,
  input  logic [31:0] out_value_a,
  input  logic [31:0] out_value_b,
  input  logic [15:0] out_delta_x,
  input  logic [15:0] out_delta_y,
  input  logic [15:0] out_flags,
  input  logic [63:0] out_timestamp,
  input  logic [6:0]  out_pending,
  input  logic [63:0] out_dropped_total,
  input  logic [6:0]  out_high_watermark,
  output int          fail_count,
  output int          awaiting
);
  typedef struct packed {
    logic [3:0]  etype;
    logic [15:0] window;
    logic [15:0] flags;
    logic [31:0] va;
    logic [31:0] vb;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [63:0] ts;
  } slot_t;

  typedef struct packed {
    logic [1:0]  status;
    slot_t       ev;
    logic [6:0]  pending;
    logic [63:0] dropped;
    logic [6:0]  peak;
  } result_t;

  slot_t       ring [eqc_pkg::QUEUE_DEPTH];
  int unsigned wr_ptr, rd_ptr, fill, peak;
  logic [63:0] drops;
  result_t     result_fifo [$];

  assign awaiting = result_fifo.size();

  function automatic logic [15:0] clamp16(logic [15:0] a, logic [15:0] b);
    int s;
    s = $signed(a) + $signed(b);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  function automatic void append_slot(slot_t s);
    if (fill >= eqc_pkg::QUEUE_DEPTH) begin
      rd_ptr = (rd_ptr + 1) % eqc_pkg::QUEUE_DEPTH;
      fill--;
      if (drops != '1) drops++;
    end
    ring[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % eqc_pkg::QUEUE_DEPTH;
    fill++;
    if (fill > peak) peak = fill;
  endfunction

  function automatic logic [1:0] push_event(slot_t s);
    int unsigned last, idx;
    slot_t o;
    if (s.etype > eqc_pkg::EV_TIMER) return eqc_pkg::ST_REJECT;
    if (s.etype inside {eqc_pkg::EV_MOVE, eqc_pkg::EV_BTNDOWN, eqc_pkg::EV_BTNUP,
                        eqc_pkg::EV_SCROLL}) begin
      s.window = 0;
      s.flags[15:8] = 0;
      if (s.etype != eqc_pkg::EV_MOVE) s.dx = 0;
      if (s.etype inside {eqc_pkg::EV_BTNDOWN, eqc_pkg::EV_BTNUP}) s.dy = 0;
      if (s.etype inside {eqc_pkg::EV_MOVE, eqc_pkg::EV_SCROLL} && fill > 0) begin
        last = (wr_ptr + eqc_pkg::QUEUE_DEPTH - 1) % eqc_pkg::QUEUE_DEPTH;
        o = ring[last];
        if (o.etype == s.etype && o.window == 0) begin
          s.dy = clamp16(o.dy, s.dy);
          if (s.etype == eqc_pkg::EV_MOVE) s.dx = clamp16(o.dx, s.dx);
          ring[last] = s;
          return eqc_pkg::ST_MERGED;
        end
      end
    end else if (s.etype inside {eqc_pkg::EV_KEYDOWN, eqc_pkg::EV_KEYUP}) begin
      s.vb = 0; s.dx = 0; s.dy = 0;
    end else begin
      s.flags = 0; s.dx = 0; s.dy = 0;
      if (s.etype != eqc_pkg::EV_RESIZE) s.vb = 0;
      if (!(s.etype inside {eqc_pkg::EV_RESIZE, eqc_pkg::EV_TIMER})) s.va = 0;
      if (s.etype inside {eqc_pkg::EV_PAINT, eqc_pkg::EV_TIMER}) begin
        if (s.window == 0) return eqc_pkg::ST_REJECT;
        idx = rd_ptr;
        for (int i = 0; i < fill; i++) begin
          if (ring[idx].etype == s.etype && ring[idx].window == s.window &&
              (s.etype != eqc_pkg::EV_TIMER || ring[idx].va == s.va))
            return eqc_pkg::ST_MERGED;
          idx = (idx + 1) % eqc_pkg::QUEUE_DEPTH;
        end
      end
    end
    append_slot(s);
    return eqc_pkg::ST_DONE;
  endfunction

  function automatic int unsigned discard_window(logic [15:0] w);
    int unsigned orig, kept, rd, wr;
    orig = fill; kept = 0; rd = rd_ptr; wr = rd_ptr;
    if (w == 0 || orig == 0) return 0;
    for (int i = 0; i < orig; i++) begin
      if (ring[rd].window != w) begin
        ring[wr] = ring[rd];
        wr = (wr + 1) % eqc_pkg::QUEUE_DEPTH;
        kept++;
      end
      rd = (rd + 1) % eqc_pkg::QUEUE_DEPTH;
    end
    wr_ptr = wr;
    fill = kept;
    if (kept == 0) begin
      wr_ptr = 0; rd_ptr = 0;
    end
    return orig - kept;
  endfunction

  function automatic result_t apply_word(logic [2:0] op, slot_t s);
    result_t r;
    r = '0;
    r.status = eqc_pkg::ST_DONE;
    case (op)
      eqc_pkg::OP_PUSH: r.status = push_event(s);
      eqc_pkg::OP_POP, eqc_pkg::OP_PEEK: begin
        if (fill == 0) r.status = eqc_pkg::ST_EMPTY;
        else begin
          r.ev = ring[rd_ptr];
          if (op == eqc_pkg::OP_POP) begin
            rd_ptr = (rd_ptr + 1) % eqc_pkg::QUEUE_DEPTH;
            fill--;
          end
        end
      end
      eqc_pkg::OP_DISCARD: r.ev.va = discard_window(s.window);
      eqc_pkg::OP_FLUSH: begin
        wr_ptr = 0; rd_ptr = 0; fill = 0;
      end
      eqc_pkg::OP_DIAG: begin
        peak = fill; drops = 0;
      end
      default: r.status = eqc_pkg::ST_REJECT;
    endcase
    r.pending = fill[6:0];
    r.dropped = drops;
    r.peak = peak[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    slot_t s;
    result_t got, want;
    if (!rst_n) begin
      wr_ptr = 0; rd_ptr = 0; fill = 0; peak = 0; drops = 0;
      result_fifo.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        s = '{in_event_type, in_window_id, in_flags, in_value_a, in_value_b,
              in_delta_x, in_delta_y, in_timestamp};
        result_fifo.push_back(apply_word(in_opcode, s));
      end
      if (out_valid && out_ready) begin
        got = '{out_status, '{out_type, out_window, out_flags, out_value_a,
                out_value_b, out_delta_x, out_delta_y, out_timestamp},
                out_pending, out_dropped_total, out_high_watermark};
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch status exp %0d got %0d, pending exp %0d got %0d",
                     $realtime, want.status, got.status, want.pending, got.pending);
            $display("  event exp %h got %h", want.ev, got.ev);
            $display("  drops exp %0d got %0d, watermark exp %0d got %0d",
                     want.dropped, got.dropped, want.peak, got.peak);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ dv/tb_top.sv @@
// stimulus and verdict for the event queue core
// depends on eqc_pkg, event_queue_coalescing_core and eqc_checker
`timescale 1ns / 1ps
module tb_top;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_ready;
  logic [2:0]  in_opcode = 0;
  logic [3:0]  in_event_type = 0;
  logic [15:0] in_window_id = 0;
  logic [31:0] in_value_a = 0, in_value_b = 0;
  logic [15:0] in_delta_x = 0, in_delta_y = 0, in_flags = 0;
  logic [63:0] in_timestamp = 0;
  logic        out_valid, out_ready = 0;
  logic [1:0]  out_status;
  logic [3:0]  out_type;
  logic [15:0] out_window, out_delta_x, out_delta_y, out_flags;
  logic [31:0] out_value_a, out_value_b;
  logic [63:0] out_timestamp, out_dropped_total;
  logic [6:0]  out_pending, out_high_watermark;
  int          fail_count, awaiting, idle_cycles;
  logic        ship_window;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  event_queue_coalescing_core DUT (.*);
  eqc_checker u_checker (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall pattern, with quiet stretches where ready stays high
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (ship_window) out_ready <= 1;
      else begin
        n = gap_len();
        if (n == 0) out_ready <= 1;
        else begin
          out_ready <= 0;
          repeat (n) @(posedge clk);
          out_ready <= 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("event_queue_coalescing_core regression: fail");
      $finish;
    end
  end

  // valid stays high straight into the next word when there is no gap
  task automatic send_word(input logic [2:0] op, input logic [3:0] et,
                           input logic [15:0] win, input logic [31:0] va,
                           input logic [31:0] vb, input logic [15:0] dx,
                           input logic [15:0] dy, input logic [15:0] fl,
                           input logic [63:0] ts, input bit nogap);
    int n;
    n = nogap ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op; in_event_type <= et; in_window_id <= win;
    in_value_a <= va; in_value_b <= vb; in_delta_x <= dx; in_delta_y <= dy;
    in_flags <= fl; in_timestamp <= ts;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_push(input logic [3:0] et, input logic [15:0] win);
    send_word(eqc_pkg::OP_PUSH, et, win, rnd32(), rnd32(), rnd16(), rnd16(),
              16'($urandom), {$urandom, $urandom}, 0);
  endtask

  initial begin
    logic [3:0]  et;
    logic [15:0] win;
    int          r;
    ship_window = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty reads, every type, saturation, rejects, dedupe, discard
    send_word(eqc_pkg::OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_word(eqc_pkg::OP_PEEK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int t = 0; t < 16; t++)
      send_word(eqc_pkg::OP_PUSH, t[3:0], 16'hffff, 32'h7fff_ffff, 32'h8000_0000,
                16'h7fff, 16'h7fff, 16'hffff, 64'hffff_ffff_ffff_ffff, 0);
    send_word(eqc_pkg::OP_PUSH, eqc_pkg::EV_MOVE, 5, 0, 0, 16'h7fff, 16'h8000, 0, 1, 0);
    send_word(eqc_pkg::OP_PUSH, eqc_pkg::EV_MOVE, 0, 1, 1, 16'h8000, 16'h8000, 16'hff,
              2, 0);
    send_word(eqc_pkg::OP_PUSH, eqc_pkg::EV_PAINT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(eqc_pkg::OP_PUSH, eqc_pkg::EV_TIMER, 16'hffff, 32'h7fff_ffff, 0, 0, 0, 0,
              3, 0);
    send_word(eqc_pkg::OP_PEEK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(eqc_pkg::OP_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(eqc_pkg::OP_DISCARD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(eqc_pkg::OP_DISCARD, 0, 16'hffff, 0, 0, 0, 0, 0, 0, 0);
    send_word(6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(eqc_pkg::OP_DIAG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(eqc_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // random: bursts of pushes over a few windows so the queue fills and wraps
    for (int i = 0; i < 1930; i++) begin
      ship_window = (i % 300) < 40;
      r = $urandom_range(0, 99);
      win = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      if (r < 70) begin
        et = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) :
                                            4'($urandom_range(0, 11));
        random_push(et, win);
      end else if (r < 80) send_word(eqc_pkg::OP_POP, 4'($urandom), 16'($urandom),
                                     0, 0, 0, 0, 0, 0, 0);
      else if (r < 86) send_word(eqc_pkg::OP_PEEK, 4'($urandom), 16'($urandom),
                                 0, 0, 0, 0, 0, 0, 0);
      else if (r < 93) send_word(eqc_pkg::OP_DISCARD, 0, win, 0, 0, 0, 0, 0, 0, 0);
      else if (r < 95) send_word(eqc_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      else if (r < 98) send_word(eqc_pkg::OP_DIAG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      else send_word(3'($urandom_range(6, 7)), 0, 0, 0, 0, 0, 0, 0, 0, 0);
    end
    in_valid <= 0;

    while (awaiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("event_queue_coalescing_core regression: pass");
    else $display("event_queue_coalescing_core regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/eqc_pkg.sv
sv/eqc_store.sv
sv/eqc_ctrl.sv
sv/event_queue_coalescing_core.sv
dv/eqc_checker.sv
dv/tb_top.sv
